[rtl/core/ppid_pkg.sv]
// Shared types and register codes for the position PID controller.
package ppid_pkg;

    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_TARGET       = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_P       = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_I       = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_D       = 3'd3;
    localparam logic [IDX_W-1:0] REG_DEAD_BAND    = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_INTEGRAL = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPEED_LIMIT  = 3'd6;

    typedef struct packed {
        logic signed [31:0] target_position;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [30:0]        dead_band;
        logic [30:0]        max_integral;
        logic [30:0]        speed_limit;
    } cfg_t;

    // error terms handed from the error stage to the multipliers
    typedef struct packed {
        logic signed [31:0] err;
        logic signed [31:0] err_sum;
        logic signed [32:0] err_delta;
    } err_item_t;

    // gain products handed to the summing / limiting stage
    typedef struct packed {
        logic signed [47:0] p_term;
        logic signed [47:0] i_term;
        logic signed [48:0] d_term;
    } term_item_t;

endpackage

[rtl/core/position_pid_deadband_speed_limit.sv]
// Position PID controller with dead band, anti-windup and speed clamp: top level.
// Three register stages (error/state, gain products, sum and clamp); a request's
// result passes through them in that order. Throughput is one request per cycle
// unless out_ready stalls; the integral and last-error update closes within the
// first stage, so requests can follow back to back.
// Reset (async, active low) clears all config registers, the integral and the
// last error, and empties the pipeline.
module position_pid_deadband_speed_limit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [ppid_pkg::IDX_W-1:0]  cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [31:0]          position,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [31:0]          speed_target,
    output logic                        limited
);
    import ppid_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       err_valid, err_ready;
    err_item_t  err_item;
    logic       term_valid, term_ready;
    term_item_t term_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET:       cfg_next.target_position = cfg_data;
                REG_GAIN_P:       cfg_next.gain_p          = cfg_data[15:0];
                REG_GAIN_I:       cfg_next.gain_i          = cfg_data[15:0];
                REG_GAIN_D:       cfg_next.gain_d          = cfg_data[15:0];
                REG_DEAD_BAND:    cfg_next.dead_band       = cfg_data[30:0];
                REG_MAX_INTEGRAL: cfg_next.max_integral    = cfg_data[30:0];
                REG_SPEED_LIMIT:  cfg_next.speed_limit     = cfg_data[30:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    ppid_error u_error (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .position  (position),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_item  (err_item)
    );

    ppid_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_item   (err_item),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .out_item  (term_item)
    );

    ppid_limit u_limit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (term_valid),
        .in_ready     (term_ready),
        .in_item      (term_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .speed_target (speed_target),
        .limited      (limited)
    );

endmodule

[rtl/core/ppid_error.sv]
// Error stage: saturated error, dead band, windowed integral and derivative delta.
module ppid_error (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppid_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    position,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ppid_pkg::err_item_t   out_item
);
    import ppid_pkg::*;

    logic               valid_reg, valid_next;
    logic signed [31:0] sum_reg, sum_next;
    logic signed [31:0] last_reg, last_next;
    err_item_t          item_reg, item_next;

    logic signed [32:0] diff;
    logic signed [31:0] err_sat;
    logic signed [32:0] err33;
    logic signed [32:0] db33;
    logic signed [32:0] mi33;
    logic signed [32:0] mi33_neg;
    logic signed [32:0] sum_add;
    logic signed [31:0] sum_clamped;
    logic signed [31:0] err_eff;
    logic               outside;
    logic               in_win;
    logic               accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        diff = $signed({cfg.target_position[31], cfg.target_position})
             - $signed({position[31], position});
        if (diff[32] != diff[31])
            err_sat = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            err_sat = diff[31:0];

        err33    = $signed({err_sat[31], err_sat});
        db33     = $signed({2'b00, cfg.dead_band});
        mi33     = $signed({2'b00, cfg.max_integral});
        mi33_neg = -mi33;

        outside = (err33 > db33) || (err33 < -db33);
        in_win  = (err33 < mi33) && (err33 > -mi33);

        sum_add = $signed({sum_reg[31], sum_reg}) + err33;
        if (sum_add > mi33)
            sum_clamped = mi33[31:0];
        else if (sum_add < mi33_neg)
            sum_clamped = mi33_neg[31:0];
        else
            sum_clamped = sum_add[31:0];

        err_eff = outside ? err_sat : 32'sd0;

        sum_next  = sum_reg;
        last_next = last_reg;
        item_next = item_reg;
        if (accept)
        begin
            if (!outside)
                sum_next = 32'sd0;
            else if (in_win)
                sum_next = sum_clamped;
            last_next           = err_eff;
            item_next.err       = err_eff;
            item_next.err_sum   = sum_next;
            item_next.err_delta = $signed({err_eff[31], err_eff})
                                - $signed({last_reg[31], last_reg});
        end

        valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sum_reg   <= '0;
            last_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            sum_reg   <= sum_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/core/ppid_mult.sv]
// Multiplier stage: the three gain products, registered.
module ppid_mult (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppid_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ppid_pkg::err_item_t   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ppid_pkg::term_item_t  out_item
);
    import ppid_pkg::*;

    logic       valid_reg, valid_next;
    term_item_t item_reg, item_next;
    logic       accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        item_next = item_reg;
        if (accept)
        begin
            item_next.p_term = $signed(cfg.gain_p) * $signed(in_item.err);
            item_next.i_term = $signed(cfg.gain_i) * $signed(in_item.err_sum);
            item_next.d_term = $signed(cfg.gain_d) * $signed(in_item.err_delta);
        end
        valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/core/ppid_limit.sv]
// Output stage: sums the PID terms and clamps to the speed limit.
module ppid_limit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppid_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ppid_pkg::term_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    speed_target,
    output logic                  limited
);
    import ppid_pkg::*;

    logic               valid_reg, valid_next;
    logic signed [31:0] speed_reg, speed_next;
    logic               limited_reg, limited_next;

    logic signed [50:0] acc;
    logic signed [50:0] sl51;
    logic signed [31:0] sl32;
    logic               over;
    logic               under;
    logic               accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        acc = $signed({{3{in_item.p_term[47]}}, in_item.p_term})
            + $signed({{3{in_item.i_term[47]}}, in_item.i_term})
            + $signed({{2{in_item.d_term[48]}}, in_item.d_term});
        sl51  = $signed({20'd0, cfg.speed_limit});
        sl32  = $signed({1'b0, cfg.speed_limit});
        over  = acc > sl51;
        under = acc < -sl51;

        speed_next   = speed_reg;
        limited_next = limited_reg;
        if (accept)
        begin
            // limit fits in 32 bits, so clamping the exact sum covers saturation
            if (over)
                speed_next = sl32;
            else if (under)
                speed_next = -sl32;
            else
                speed_next = acc[31:0];
            limited_next = over || under;
        end
        valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        speed_reg   <= speed_next;
        limited_reg <= limited_next;
    end

    assign out_valid    = valid_reg;
    assign speed_target = speed_reg;
    assign limited      = limited_reg;

endmodule

[rtl/core/ppid_checker.sv]
// Port-level checks for the position PID controller, bound to the top level.
module ppid_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [ppid_pkg::IDX_W-1:0]  cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [31:0]          position,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [31:0]          speed_target,
    input  logic                        limited
);
    import ppid_pkg::*;

    // shadow of the speed limit as written through the config port
    logic [30:0]        limit_reg;
    logic signed [31:0] limit_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else if (cfg_write && cfg_index == REG_SPEED_LIMIT)
            limit_reg <= cfg_data[30:0];
    end

    assign limit_s = $signed({1'b0, limit_reg});

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(speed_target) && $stable(limited))
        else $error("stalled result changed");

    a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (speed_target <= limit_s) && (speed_target >= -limit_s))
        else $error("speed target exceeds speed limit");

    a_limited_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && limited |-> (speed_target == limit_s) || (speed_target == -limit_s))
        else $error("limited result not at the clamp value");

endmodule

bind position_pid_deadband_speed_limit ppid_checker u_ppid_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the position PID controller with dead band and speed clamp.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ppid_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_SHOWN = 40;
    localparam int RANDOM_ITEMS = 1500;
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] speed;
        logic               lim;
    } speed_cmd_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [31:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic signed [31:0]  position = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [31:0]  speed_target;
    logic                limited;

    position_pid_deadband_speed_limit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .position     (position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .speed_target (speed_target),
        .limited      (limited)
    );

    // shadow of the controller: registers, integral, previous error
    cfg_t               cfg_shadow = '0;
    logic signed [31:0] integ_sum = '0;
    logic signed [31:0] prev_error = '0;
    speed_cmd_t         speed_cmd_q[$];
    int                 mismatches = 0;
    bit                 idle_in = 1'b0;
    bit                 idle_out = 1'b0;
    int                 hold_len = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic speed_cmd_t pid_predict(input logic signed [31:0] pos);
        longint     e;
        longint     acc;
        longint     db;
        longint     mi;
        longint     sl;
        speed_cmd_t r;
        db = longint'(cfg_shadow.dead_band);
        mi = longint'(cfg_shadow.max_integral);
        sl = longint'(cfg_shadow.speed_limit);
        e = clip(longint'(cfg_shadow.target_position) - longint'(pos), S32_MIN, S32_MAX);
        acc = 0;
        if (e > db || e < -db)
        begin
            acc = longint'(cfg_shadow.gain_p) * e;
            // integrate only strictly inside the window
            if (e < mi && e > -mi)
                integ_sum = 32'(clip(longint'(integ_sum) + e, -mi, mi));
            acc += longint'(cfg_shadow.gain_i) * longint'(integ_sum);
        end
        else
        begin
            integ_sum = '0;
            e = 0;
        end
        acc += longint'(cfg_shadow.gain_d) * (e - longint'(prev_error));
        prev_error = 32'(e);
        r.speed = 32'(clip(clip(acc, S32_MIN, S32_MAX), -sl, sl));
        r.lim = (acc > sl) || (acc < -sl);
        return r;
    endfunction

    function automatic logic signed [15:0] draw_gain();
        case ($urandom_range(0, 3))
            0: return 16'($urandom());
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic [30:0] draw_magnitude(input int typical);
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return MAG_MAX;
            2: return 31'($urandom());
            default: return 31'($urandom_range(0, typical));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_result(input logic signed [31:0] got_speed, input logic got_lim);
        speed_cmd_t want;
        if (speed_cmd_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result speed_target=%0d", got_speed));
            return;
        end
        want = speed_cmd_q.pop_front();
        if (got_speed !== want.speed)
            report_mismatch($sformatf("speed_target got %0d want %0d", got_speed, want.speed));
        if (got_lim !== want.lim)
            report_mismatch($sformatf("limited got %b want %b (speed %0d)",
                                      got_lim, want.lim, want.speed));
    endtask

    // entered at a rising edge; returns at the edge that accepts the request
    task automatic send_position(input logic signed [31:0] pos);
        int gap;
        gap = idle_in ? $urandom_range(0, 9) : 0;
        if (gap == 0)
        begin
            in_valid <= 1'b1;
            position <= pos;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            in_valid <= 1'b1;
            position <= pos;
        end
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        speed_cmd_q.push_back(pid_predict(pos));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (speed_cmd_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_TARGET:       cfg_shadow.target_position = data;
            REG_GAIN_P:       cfg_shadow.gain_p = data[15:0];
            REG_GAIN_I:       cfg_shadow.gain_i = data[15:0];
            REG_GAIN_D:       cfg_shadow.gain_d = data[15:0];
            REG_DEAD_BAND:    cfg_shadow.dead_band = data[30:0];
            REG_MAX_INTEGRAL: cfg_shadow.max_integral = data[30:0];
            REG_SPEED_LIMIT:  cfg_shadow.speed_limit = data[30:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // unused upper data bits carry noise; the block must drop them
    task automatic set_config(input logic signed [31:0] tgt,
                              input logic signed [15:0] kp,
                              input logic signed [15:0] ki,
                              input logic signed [15:0] kd,
                              input logic [30:0] db,
                              input logic [30:0] mi,
                              input logic [30:0] sl);
        wait_drained();
        write_reg(REG_TARGET, tgt);
        write_reg(REG_GAIN_P, {16'($urandom()), kp});
        write_reg(REG_GAIN_I, {16'($urandom()), ki});
        write_reg(REG_GAIN_D, {16'($urandom()), kd});
        write_reg(REG_DEAD_BAND, {1'($urandom()), db});
        write_reg(REG_MAX_INTEGRAL, {1'($urandom()), mi});
        write_reg(REG_SPEED_LIMIT, {1'($urandom()), sl});
        write_reg(REG_UNUSED, $urandom());
    endtask

    task automatic test_reset_state();
        send_position(32'sd0);
        send_position(POS_MAX);
        send_position(POS_MIN);
    endtask

    task automatic test_error_saturation();
        set_config(POS_MAX, 16'sd1, 16'sd0, 16'sd0, 31'd0, 31'd0, MAG_MAX);
        send_position(POS_MIN);
        send_position(POS_MAX);
        set_config(POS_MIN, 16'sd1, 16'sd0, 16'sd0, 31'd0, 31'd0, MAG_MAX);
        send_position(POS_MAX);
        send_position(POS_MIN);
    endtask

    task automatic test_dead_band();
        int errs[6] = '{101, 100, -100, -101, 150, 0};
        set_config(32'sd0, 16'sd256, 16'sd256, 16'sd256, 31'd100, 31'd1000, MAG_MAX);
        foreach (errs[i])
            send_position(-errs[i]);
    endtask

    task automatic test_integral_window();
        int errs[5] = '{49, 50, 60, 49, -60};
        int low[3] = '{20, 5, -10};
        set_config(32'sd0, 16'sd0, 16'sd256, 16'sd0, 31'd0, 31'd50, MAG_MAX);
        foreach (errs[i])
            send_position(-errs[i]);
        // shrink the window below the stored integral
        wait_drained();
        write_reg(REG_MAX_INTEGRAL, 32'd10);
        foreach (low[i])
            send_position(-low[i]);
    endtask

    task automatic test_output_limit();
        set_config(32'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 31'd0, MAG_MAX, MAG_MAX);
        send_position(POS_MIN);
        send_position(POS_MAX);
        set_config(32'sd0, 16'sh8000, 16'sh8000, 16'sh8000, 31'd0, MAG_MAX, 31'd1000);
        send_position(32'sd5);
        send_position(POS_MAX);
        // zero speed limit
        set_config(32'sd12345, 16'sd256, 16'sd0, 16'sd0, 31'd0, 31'd0, 31'd0);
        send_position(32'sd12345);
        send_position(32'sd0);
    endtask

    task automatic test_back_pressure();
        set_config(32'sd1000, 16'sd300, 16'sd20, 16'sd100, 31'd5, 31'd5000, 31'd1000000);
        idle_in = 1'b0;
        idle_out = 1'b0;
        wait_drained();
        hold_len = 120;
        repeat (40)
            send_position(32'sd1000 + int'($urandom_range(0, 4000)) - 2000);
        wait_drained();
        repeat (20)
            send_position(32'sd1000 + int'($urandom_range(0, 4000)) - 2000);
    endtask

    task automatic test_random_stream();
        int                 done;
        int                 n;
        int                 r;
        longint             e;
        longint             db;
        longint             mi;
        logic signed [31:0] tgt;
        logic signed [31:0] pos;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: tgt = 32'sd0;
                1: tgt = $urandom();
                2: tgt = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
                default: tgt = int'($urandom_range(0, 200000)) - 100000;
            endcase
            set_config(tgt, draw_gain(), draw_gain(), draw_gain(),
                       draw_magnitude(200), draw_magnitude(100000), draw_magnitude(1 << 24));
            idle_in = $urandom_range(0, 3) != 0;
            idle_out = $urandom_range(0, 3) != 0;
            db = longint'(cfg_shadow.dead_band);
            mi = longint'(cfg_shadow.max_integral);
            n = $urandom_range(40, 120);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r >= 95)
                    pos = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
                else if (r >= 85)
                    pos = $urandom();
                else
                begin
                    if (r < 20)
                        e = longint'($urandom_range(0, 32'(db)));
                    else if (r < 55 && mi > db + 1)
                        e = longint'($urandom_range(32'(db + 1), 32'(mi - 1)));
                    else if (r < 75)
                        e = longint'($urandom_range(0, 1 << 16));
                    else
                    begin
                        // edges of the dead band and of the integration window
                        case ($urandom_range(0, 3))
                            0: e = db;
                            1: e = db + 1;
                            2: e = mi;
                            default: e = mi - 1;
                        endcase
                    end
                    if ($urandom_range(0, 1))
                        e = -e;
                    pos = cfg_shadow.target_position - 32'(e);
                end
                send_position(pos);
            end
            done += n;
        end
    endtask

    // result side: per-request stall, optional long hold-off
    initial
    begin
        int w;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_len > 0)
            begin
                w = hold_len;
                hold_len = 0;
            end
            else
                w = idle_out ? $urandom_range(0, 9) : 0;
            if (w == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
                out_ready <= 1'b1;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            check_result(speed_target, limited);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_error_saturation();
        test_dead_band();
        test_integral_window();
        test_output_limit();
        test_back_pressure();
        test_random_stream();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
